>>> rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the response-ratio tick scheduler.
// Holds the operation codes and the command and status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int IdW  = 8;
	localparam int SvcW = 10;
	localparam logic [SvcW-1:0] RunMax = 10'd1023;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic start_add;   // perform an add with the captured item
		logic scan_init;   // begin a tick: pick the running job as first candidate
		logic scan_step;   // compare one entry of the ready order
		logic mult_step;   // register the cross products of the current entry
		logic commit;      // apply the tick result to the tables
	} rrts_cmd_t;

	typedef struct packed {
		logic scan_done;   // every entry of the ready order has been compared
		logic have;        // a candidate has been found
	} rrts_sts_t;

endpackage

>>> rtl/core/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl: controller of the scheduler.
// Sequences add and tick operations and drives the output register handshake.
// ----------------------------------------------------------------------------
module rrts_ctrl
	import rrts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      in_op,
	input  logic      out_fire,
	input  rrts_sts_t sts,
	output rrts_cmd_t cmd,
	output logic      busy,
	output logic      out_valid
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_CMP, S_COMMIT, S_HOLD} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   res_load;

	// Input is taken only in S_IDLE; the result register must be free too.
	assign busy      = (state_q != S_IDLE) || (out_valid_q && !out_fire);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && in_op == OP_ADD) begin
					cmd.start_add = 1'b1;
					res_load = 1'b1;
				end
				if (in_fire && in_op == OP_TICK) cmd.scan_init = 1'b1;
			end
			S_MUL:    cmd.mult_step = !sts.scan_done;
			S_CMP:    cmd.scan_step = 1'b1;
			S_COMMIT: begin
				cmd.commit = 1'b1;
				res_load = 1'b1;
			end
			S_HOLD:   ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && in_op == OP_TICK) state_q <= S_MUL;
				end
				S_MUL: begin
					if (sts.scan_done) state_q <= S_COMMIT;
					else state_q <= S_CMP;
				end
				S_CMP:    state_q <= S_MUL;
				S_COMMIT: state_q <= S_IDLE;
				S_HOLD:   state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not load the result register");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_fire)
		else $error("item accepted while a tick is in progress");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |=> (state_q == S_MUL))
		else $error("compare step not followed by the next multiply");

endmodule

>>> rtl/core/rrts_dpath.sv
// ----------------------------------------------------------------------------
// rrts_dpath: datapath of the scheduler.
// Job tables, ready order queue, the cross-multiply comparator and the
// result register.
// ----------------------------------------------------------------------------
module rrts_dpath
	import rrts_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int WAIT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rrts_cmd_t         cmd,
	input  logic [IdW-1:0]    in_id,
	input  logic [SvcW-1:0]   in_svc,
	output rrts_sts_t         sts,
	output logic [IdW-1:0]    res_id,
	output logic              res_ran,
	output logic              res_fin,
	output logic              res_rej,
	output logic [SvcW-1:0]   res_run
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int SumW = WAIT_BITS + 1;
	localparam int ProdW = SumW + SvcW;
	localparam logic [WAIT_BITS-1:0] WaitMax = {WAIT_BITS{1'b1}};

	logic [SLOTS-1:0]     valid_q;
	logic [SvcW-1:0]      rem_q  [SLOTS];
	logic [WAIT_BITS-1:0] wait_q [SLOTS];
	logic [SvcW-1:0]      runc_q [SLOTS];
	logic [IdW-1:0]       id_q   [SLOTS];
	logic [SW-1:0]        ord_q  [SLOTS];
	logic [LW-1:0]        len_q;
	logic                 rv_q;
	logic [SW-1:0]        rs_q;

	logic                 have_q;
	logic [SW-1:0]        best_q;
	logic [LW-1:0]        idx_q;
	logic [LW-1:0]        bpos_q;   // order position of best, or len if running
	logic [ProdW-1:0]     lhs_q, rhs_q;

	logic [IdW-1:0]  r_id_q;
	logic            r_ran_q, r_fin_q, r_rej_q;
	logic [SvcW-1:0] r_run_q;

	assign res_id  = r_id_q;
	assign res_ran = r_ran_q;
	assign res_fin = r_fin_q;
	assign res_rej = r_rej_q;
	assign res_run = r_run_q;

	// Lowest free slot.
	logic          free_any;
	logic [SW-1:0] free_slot;
	always_comb begin
		free_any = 1'b0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	logic [SW-1:0] cand;
	assign cand = ord_q[idx_q[SW-1:0]];
	assign sts.scan_done = (idx_q >= len_q);
	assign sts.have = have_q;

	logic [SumW-1:0] sum_c, sum_b;
	assign sum_c = SumW'(wait_q[cand]) + SumW'(rem_q[cand]);
	assign sum_b = SumW'(wait_q[best_q]) + SumW'(rem_q[best_q]);

	// Commit values for the picked job.
	logic          preempt;
	logic [SvcW-1:0] rem_new, run_new;
	logic          fin;
	assign preempt = !(rv_q && valid_q[rs_q]) || (best_q != rs_q);
	assign rem_new = rem_q[best_q] - SvcW'(1);
	assign run_new = (runc_q[best_q] < RunMax) ? runc_q[best_q] + SvcW'(1) : runc_q[best_q];
	assign fin     = (rem_new == '0);

	always_ff @(posedge clk) begin
		if (cmd.mult_step) begin
			lhs_q <= ProdW'(sum_c * rem_q[best_q]);
			rhs_q <= ProdW'(sum_b * rem_q[cand]);
		end
		if (cmd.scan_init) begin
			best_q <= rs_q;
			bpos_q <= len_q;
		end else if (cmd.scan_step) begin
			if (valid_q[cand] && (!have_q || lhs_q > rhs_q)) begin
				best_q <= cand;
				bpos_q <= idx_q;
			end
		end
		if (cmd.start_add) begin
			r_id_q  <= in_id;
			r_ran_q <= 1'b0;
			r_fin_q <= 1'b0;
			r_run_q <= '0;
			r_rej_q <= (in_svc == '0) || !free_any;
			if (in_svc != '0 && free_any) begin
				rem_q[free_slot]  <= in_svc;
				wait_q[free_slot] <= '0;
				runc_q[free_slot] <= '0;
				id_q[free_slot]   <= in_id;
				ord_q[len_q[SW-1:0]] <= free_slot;
			end
		end
		if (cmd.commit) begin
			r_rej_q <= 1'b0;
			r_ran_q <= have_q;
			r_id_q  <= have_q ? id_q[best_q] : '0;
			r_fin_q <= have_q && fin;
			r_run_q <= have_q ? run_new : '0;
			if (have_q) begin
				rem_q[best_q]  <= rem_new;
				runc_q[best_q] <= run_new;
				// Ready order after removal of best and append of the preempted job;
				// each remaining entry waits one more tick.
				for (int i = 0; i < SLOTS; i++) begin
					logic [SW-1:0] s;
					s = ord_q[i];
					if (preempt && LW'(i) >= bpos_q && i + 1 < SLOTS)
						s = ord_q[i+1];
					if (preempt && rv_q && valid_q[rs_q]) begin
						if (LW'(i) == len_q - LW'(1)) s = rs_q;
					end
					ord_q[i] <= s;
				end
				for (int i = 0; i < SLOTS; i++) begin
					logic inq;
					logic [SW-1:0] s;
					s = ord_q[i];
					inq = LW'(i) < len_q && !(preempt && LW'(i) == bpos_q);
					if (inq && wait_q[s] != WaitMax) wait_q[s] <= wait_q[s] + 1'b1;
				end
				if (preempt && rv_q && valid_q[rs_q] && wait_q[rs_q] != WaitMax)
					wait_q[rs_q] <= wait_q[rs_q] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			len_q   <= '0;
			rv_q    <= 1'b0;
			rs_q    <= '0;
			have_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.start_add && in_svc != '0 && free_any) begin
				valid_q[free_slot] <= 1'b1;
				len_q <= len_q + LW'(1);
			end
			if (cmd.scan_init) begin
				have_q <= rv_q && valid_q[rs_q];
				idx_q  <= '0;
			end else if (cmd.scan_step) begin
				if (valid_q[cand] && (!have_q || lhs_q > rhs_q)) have_q <= 1'b1;
				idx_q <= idx_q + LW'(1);
			end
			if (cmd.commit) begin
				if (!have_q) begin
					rv_q <= 1'b0;
				end else begin
					if (preempt) begin
						if (!(rv_q && valid_q[rs_q])) len_q <= len_q - LW'(1);
					end
					if (fin) begin
						valid_q[best_q] <= 1'b0;
						rv_q <= 1'b0;
						rs_q <= '0;
					end else begin
						rv_q <= 1'b1;
						rs_q <= best_q;
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(SLOTS))
		else $error("ready order overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && have_q |-> valid_q[best_q])
		else $error("picked job is not valid");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && have_q |-> rem_q[best_q] != '0)
		else $error("picked job has no remaining service");

endmodule

>>> rtl/core/response_ratio_tick_scheduler.sv
// ----------------------------------------------------------------------------
// response_ratio_tick_scheduler: preemptive highest response ratio next.
//
// The slave channel takes one beat per operation. tuser holds op (0 = add,
// 1 = tick); tdata holds job_id (bits 7:0) and service_time (bits 17:8).
// An add beat loads a job; a tick beat runs the job with the highest
// (wait+remaining)/remaining ratio for one tick, compared exactly by
// cross-multiplication.
// The master channel gives one beat for every input beat. tdata holds
// job_id_out, ran, finished, rejected and run_ticks from bit 0 upward.
// An add's result appears in the cycle after acceptance.
// A tick walks the ready order: for each queued job the single multiplier
// pair produces both cross products in S_MUL, S_CMP compares them, and
// S_COMMIT then applies the result to the tables.
// A full table holds 16 jobs.
// Reset empties the table and the ready order; no job is running.
// The result sits in an output register; while the receiver stalls with
// that register full, no new beat is accepted.
// ----------------------------------------------------------------------------
module response_ratio_tick_scheduler
	import rrts_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int WAIT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // job_id, service_time
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // job_id_out, ran, finished, rejected, run_ticks
);

	rrts_cmd_t cmd;
	rrts_sts_t sts;
	logic busy, in_fire, out_fire;
	logic [IdW-1:0]  res_id;
	logic            res_ran, res_fin, res_rej;
	logic [SvcW-1:0] res_run;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {3'b000, res_run, res_rej, res_fin, res_ran, res_id};

	rrts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_op(s_axis_tuser),
		.out_fire(out_fire), .sts(sts), .cmd(cmd), .busy(busy),
		.out_valid(m_axis_tvalid)
	);

	rrts_dpath #(.SLOTS(SLOTS), .WAIT_BITS(WAIT_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_id(s_axis_tdata[7:0]), .in_svc(s_axis_tdata[17:8]), .sts(sts),
		.res_id(res_id), .res_ran(res_ran), .res_fin(res_fin),
		.res_rej(res_rej), .res_run(res_run)
	);

endmodule

>>> sim/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker: scoreboard for the response-ratio tick scheduler.
// Watches both stream channels, keeps its own copy of the job table to
// work out the result of every accepted beat, and compares each result
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rrts_checker
	import rrts_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int WAIT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	output int          errors,
	output int          pending,
	output int          table_jobs
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SvcW-1:0] run_ticks;
		logic            rejected;
		logic            finished;
		logic            ran;
		logic [IdW-1:0]  job_id_out;
	} sched_result_t;

	logic                 used_q [SLOTS];
	logic [SvcW-1:0]      left_q [SLOTS];
	logic [WAIT_BITS-1:0] wait_q [SLOTS];
	logic [SvcW-1:0]      runs_q [SLOTS];
	logic [IdW-1:0]       id_q   [SLOTS];
	int                   ready_q[$];
	logic                 busy;
	int                   cur_slot;
	sched_result_t        expected_results[$];

	function automatic int count_jobs();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (used_q[i]) n++;
		return n;
	endfunction

	// Strictly higher response ratio of slot a over slot b, by cross products.
	function automatic bit higher_ratio(int a, int b);
		longint unsigned lhs, rhs;
		lhs = (longint'(wait_q[a]) + left_q[a]) * left_q[b];
		rhs = (longint'(wait_q[b]) + left_q[b]) * left_q[a];
		return lhs > rhs;
	endfunction

	function automatic sched_result_t schedule_beat(logic op, logic [23:0] d);
		sched_result_t r;
		int free_slot, best;
		bit have;
		logic [SvcW-1:0] svc;
		r = '0;
		svc = d[17:8];
		if (op == OP_ADD) begin
			r.job_id_out = d[7:0];
			free_slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--) if (!used_q[i]) free_slot = i;
			if (svc == 0 || free_slot < 0) begin
				r.rejected = 1'b1;
				return r;
			end
			used_q[free_slot] = 1'b1;
			left_q[free_slot] = svc;
			wait_q[free_slot] = '0;
			runs_q[free_slot] = '0;
			id_q[free_slot]   = d[7:0];
			ready_q.push_back(free_slot);
			return r;
		end
		have = busy;
		best = cur_slot;
		foreach (ready_q[i])
			if (!have || higher_ratio(ready_q[i], best)) begin
				have = 1'b1;
				best = ready_q[i];
			end
		if (!have) return r;
		if (!busy || best != cur_slot) begin
			if (busy) ready_q.push_back(cur_slot);
			foreach (ready_q[i])
				if (ready_q[i] == best) begin
					ready_q.delete(i);
					break;
				end
		end
		left_q[best]--;
		if (runs_q[best] != RunMax) runs_q[best]++;
		r.job_id_out = id_q[best];
		r.ran = 1'b1;
		r.run_ticks = runs_q[best];
		if (left_q[best] == 0) begin
			r.finished = 1'b1;
			used_q[best] = 1'b0;
			busy = 1'b0;
			cur_slot = 0;
		end else begin
			busy = 1'b1;
			cur_slot = best;
		end
		foreach (ready_q[i])
			if (wait_q[ready_q[i]] != '1) wait_q[ready_q[i]]++;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t got, exp_r;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) used_q[i] = 1'b0;
			ready_q.delete();
			expected_results.delete();
			busy = 1'b0;
			cur_slot = 0;
			errors = 0;
			pending = 0;
			table_jobs = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[20:0];
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: %h", m_axis_tdata);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.job_id_out !== exp_r.job_id_out) begin
						$error("job_id_out: expected %0d, got %0d", exp_r.job_id_out,
							got.job_id_out);
						errors++;
					end
					if (got.ran !== exp_r.ran) begin
						$error("ran: expected %0d, got %0d", exp_r.ran, got.ran);
						errors++;
					end
					if (got.finished !== exp_r.finished) begin
						$error("finished: expected %0d, got %0d", exp_r.finished,
							got.finished);
						errors++;
					end
					if (got.rejected !== exp_r.rejected) begin
						$error("rejected: expected %0d, got %0d", exp_r.rejected,
							got.rejected);
						errors++;
					end
					if (got.run_ticks !== exp_r.run_ticks) begin
						$error("run_ticks: expected %0d, got %0d", exp_r.run_ticks,
							got.run_ticks);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(schedule_beat(s_axis_tuser, s_axis_tdata));
			pending = expected_results.size();
			table_jobs = count_jobs();
		end
	end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench of the response-ratio tick scheduler.
// Drives add and tick beats, first a directed set and then random traffic
// in phases with differing idle and stall patterns, and reports the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam int WatchdogLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	int          errors, pending, table_jobs;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;

	always #1 clk = ~clk;

	response_ratio_tick_scheduler u_top (.*);

	rrts_checker u_chk (.*);

	// The receiver stalls at random, by the percentage of the current phase.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// The watchdog counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Send one beat, holding it until the handshake completes. The beat stays
	// on the bus until the next call or a drain replaces or withdraws it.
	task automatic send_op(logic op, logic [7:0] id, logic [9:0] svc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser  <= op;
		s_axis_tdata  <= {6'($urandom), svc, id};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Mostly short services so that jobs finish; a few long and extreme ones.
	function automatic logic [9:0] pick_service();
		int p;
		p = $urandom_range(99);
		if (p < 3) return 10'd0;
		if (p < 70) return 10'($urandom_range(1, 12));
		if (p < 95) return 10'($urandom_range(1, 80));
		return 10'($urandom);
	endfunction

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: idle tick, rejections, a full table, extreme ids.
		send_op(OP_TICK, 8'd0, 10'd0);
		send_op(OP_ADD, 8'hFF, 10'd0);
		send_op(OP_ADD, 8'h00, 10'd1);
		send_op(OP_TICK, 8'h55, 10'h3FF);
		send_op(OP_TICK, 8'h00, 10'd0);
		for (int i = 0; i < 16; i++)
			send_op(OP_ADD, 8'(i * 17), (i == 0) ? 10'h3FF : 10'(i + 1));
		send_op(OP_ADD, 8'hAA, 10'd5);
		send_op(OP_TICK, 8'd0, 10'd0);
		send_op(OP_TICK, 8'd0, 10'd0);
		drain_results();

		// Random part: four phases of sender idling and receiver stalls, with one full pause mid-way.
		for (int n = 0; n < 1450; n++) begin
			phase = n / 363;
			send_idle_pct  = (phase == 1) ? 71 : (phase == 3) ? 26 : 0;
			recv_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 26 : 0;
			if (n == 700) drain_results();
			if ($urandom_range(99) < ((table_jobs > 10) ? 85 : 55))
				send_op(OP_TICK, 8'($urandom), 10'($urandom));
			else
				send_op(OP_ADD, 8'($urandom), pick_service());
		end

		send_idle_pct = 0;
		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rrts_pkg.sv
rtl/core/rrts_ctrl.sv
rtl/core/rrts_dpath.sv
rtl/core/response_ratio_tick_scheduler.sv
sim/rrts_checker.sv
sim/tb.sv
